### design/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the header probe checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define WRHP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define WRHP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/wrhp_pkg.sv
// ---------------------------------------------------------------------------
// wrhp_pkg
// Types, codes and constants shared by the WebP RIFF header probe.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package wrhp_pkg;

   // byte position only matters up to the minimum file length, so saturate there
   localparam int POS_SAT  = 19;
   localparam int POS_BITS = $clog2(POS_SAT + 1);

   localparam int DIM_BITS  = 25;
   localparam int PIX_BITS  = 48;
   localparam int PROD_BITS = 2 * DIM_BITS;

   // status codes
   localparam logic [2:0] STATUS_OK          = 3'd0;
   localparam logic [2:0] STATUS_TRUNCATED   = 3'd1;
   localparam logic [2:0] STATUS_BAD_MAGIC   = 3'd2;
   localparam logic [2:0] STATUS_CORRUPT     = 3'd3;
   localparam logic [2:0] STATUS_DIM_REJECT  = 3'd4;
   localparam logic [2:0] STATUS_UNSUPPORTED = 3'd5;

   // register indexes
   localparam logic [1:0] CSR_MAX_WIDTH   = 2'd0;
   localparam logic [1:0] CSR_MAX_HEIGHT  = 2'd1;
   localparam logic [1:0] CSR_MAX_PIXELS  = 2'd2;
   localparam logic [1:0] CSR_HEADER_ONLY = 2'd3;

   localparam logic [DIM_BITS-1:0] RESET_MAX_WIDTH  = DIM_BITS'(16384);
   localparam logic [DIM_BITS-1:0] RESET_MAX_HEIGHT = DIM_BITS'(16384);
   localparam logic [PIX_BITS-1:0] RESET_MAX_PIXELS = PIX_BITS'(268435456);

   // chunk kinds
   localparam logic [1:0] KIND_OTHER = 2'd0;
   localparam logic [1:0] KIND_VP8X  = 2'd1;
   localparam logic [1:0] KIND_VP8   = 2'd2;
   localparam logic [1:0] KIND_ANMF  = 2'd3;

   localparam logic [31:0] TAG_VP8X = 32'h5650_3858;
   localparam logic [31:0] TAG_VP8  = 32'h5650_3820;
   localparam logic [31:0] TAG_ANMF = 32'h414e_4d46;

   localparam logic [31:0] MAGIC_RIFF = 32'h5249_4646;
   localparam logic [31:0] MAGIC_WEBP = 32'h5745_4250;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]          status;
      logic [DIM_BITS-1:0] image_width;
      logic [DIM_BITS-1:0] image_height;
      logic [31:0]         frame_total;
      logic                alpha_present;
      logic [7:0]          format_flags;
   } rsp_type;

   typedef struct packed {
      logic [DIM_BITS-1:0] max_width;
      logic [DIM_BITS-1:0] max_height;
      logic [PIX_BITS-1:0] max_pixels;
      logic                header_only_mode;
   } cfg_type;

   // end-of-file snapshot of the walker state
   typedef struct packed {
      logic [2:0]          early_status;
      logic                check_limits;
      logic [DIM_BITS-1:0] width;
      logic [DIM_BITS-1:0] height;
      logic [31:0]         frames;
      logic [7:0]          flags;
   } snap_type;

   typedef struct packed {
      snap_type             snap;
      logic [PROD_BITS-1:0] pixels;
   } prod_type;

endpackage
`default_nettype wire

### design/webp_riff_header_probe_top.sv
// ---------------------------------------------------------------------------
// webp_riff_header_probe_top
// Streaming WebP RIFF container header probe with limit checking.
// ---------------------------------------------------------------------------
// Takes a WebP file as one byte request per clock while not stalled, with
// last_byte marking the final byte, and answers each file with exactly one
// response carrying the status, image size, frame count and flags. One byte
// is accepted every cycle with no gaps while the result stages are not backed
// up: the chunk walker updates its counters and shift registers in the cycle
// of acceptance. The response for a file passes through the snapshot
// register, the 25x25 multiplier register and the output register, and a new
// file may start on the very next byte. Requests keep flowing while a response
// waits; the intake stalls only once every result stage holds an untaken
// response. Limit registers are written through the csr_ port and must be
// written only between files.
`timescale 1ns / 1ps
`default_nettype none
module webp_riff_header_probe_top
   import wrhp_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire req_type             req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output rsp_type                  rsp_data,
   input  wire logic                csr_we,
   input  wire logic [1:0]          csr_index,
   input  wire logic [PIX_BITS-1:0] csr_wdata
);

   cfg_type  cfg_ff, cfg_in;
   snap_type snap;
   snap_type s1_ff, s1_in;
   prod_type s2_ff, s2_in;
   rsp_type  rsp_ff, rsp_in;
   rsp_type  rsp_form;
   logic     s1_valid_ff, s1_valid_in;
   logic     s2_valid_ff, s2_valid_in;
   logic     rsp_valid_ff, rsp_valid_in;
   logic     rsp_adv, s2_adv, s1_adv;
   logic     step;

   // Configuration: decode the index, keep everything else
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_WIDTH:   cfg_in.max_width        = csr_wdata[DIM_BITS-1:0];
            CSR_MAX_HEIGHT:  cfg_in.max_height       = csr_wdata[DIM_BITS-1:0];
            CSR_MAX_PIXELS:  cfg_in.max_pixels       = csr_wdata;
            CSR_HEADER_ONLY: cfg_in.header_only_mode = csr_wdata[0];
         endcase
      end
   end

   // Stage advance: a stage moves when its successor is empty or moving
   assign rsp_adv   = !rsp_valid_ff || rsp_ready;
   assign s2_adv    = !s2_valid_ff || rsp_adv;
   assign s1_adv    = !s1_valid_ff || s2_adv;
   assign req_ready = s1_adv;
   assign step      = req_valid && req_ready;

   wrhp_chunk_walker u_walker (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .req_data (req_data),
      .snap     (snap)
   );

   // Snapshot stage: capture the walker state at a last byte only
   assign s1_valid_in = s1_adv ? (step && req_data.last_byte) : s1_valid_ff;
   assign s1_in       = s1_adv ? snap : s1_ff;

   // Product stage: register width times height ahead of the compare
   assign s2_valid_in = s2_adv ? s1_valid_ff : s2_valid_ff;
   always_comb begin
      s2_in = s2_ff;
      if (s2_adv) begin
         s2_in.snap   = s1_ff;
         s2_in.pixels = s1_ff.width * s1_ff.height;
      end
   end

   wrhp_result_form u_form (
      .prod (s2_ff),
      .cfg  (cfg_ff),
      .rsp  (rsp_form)
   );

   // Output register: hold the response until it is taken
   assign rsp_valid_in = rsp_adv ? s2_valid_ff : rsp_valid_ff;
   assign rsp_in       = rsp_adv ? rsp_form : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_width        <= RESET_MAX_WIDTH;
         cfg_ff.max_height       <= RESET_MAX_HEIGHT;
         cfg_ff.max_pixels       <= RESET_MAX_PIXELS;
         cfg_ff.header_only_mode <= 1'b1;
         s1_valid_ff             <= 1'b0;
         s2_valid_ff             <= 1'b0;
         rsp_valid_ff            <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset
   always_ff @(posedge clock) begin
      s1_ff  <= s1_in;
      s2_ff  <= s2_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

### design/wrhp_chunk_walker.sv
// ---------------------------------------------------------------------------
// wrhp_chunk_walker
// Per-byte magic check and RIFF chunk walk; emits the end-of-file snapshot.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module wrhp_chunk_walker
   import wrhp_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     step,
   input  wire req_type  req_data,
   output snap_type      snap
);

   logic [POS_BITS-1:0] pos_ff, pos_nx, pos_in;
   logic                magic_ff, magic_nx, magic_in;
   logic [2:0]          hidx_ff, hidx_nx, hidx_in;
   logic [31:0]         tag_ff, tag_nx, tag_in;
   logic [31:0]         len_ff, len_nx, len_in;
   logic [31:0]         left_ff, left_nx, left_in;
   logic                inpay_ff, inpay_nx, inpay_in;
   logic                pad_ff, pad_nx, pad_in;
   logic [1:0]          kind_ff, kind_nx, kind_in;
   logic [3:0]          pidx_ff, pidx_nx, pidx_in;
   logic [23:0]         pw_ff, pw_nx, pw_in;
   logic [23:0]         ph_ff, ph_nx, ph_in;
   logic [7:0]          pf_ff, pf_nx, pf_in;
   logic [DIM_BITS-1:0] fw_ff, fw_nx, fw_in;
   logic [DIM_BITS-1:0] fh_ff, fh_nx, fh_in;
   logic [7:0]          ff_ff, ff_nx, ff_in;
   logic [31:0]         frames_ff, frames_nx, frames_in;

   logic [7:0]  b;
   logic [7:0]  expect_byte;
   logic [31:0] len_full;
   logic        finish;
   logic        clear;

   assign b = req_data.data_byte;

   // magic bytes, most significant first
   always_comb begin
      if (pos_ff < POS_BITS'(4)) begin
         expect_byte = MAGIC_RIFF[8*(3 - int'(pos_ff[1:0])) +: 8];
      end else begin
         expect_byte = MAGIC_WEBP[8*(3 - int'(pos_ff[1:0])) +: 8];
      end
   end

   assign len_full = {b, len_ff[23:0]};

   always_comb begin
      pos_nx    = pos_ff;
      magic_nx  = magic_ff;
      hidx_nx   = hidx_ff;
      tag_nx    = tag_ff;
      len_nx    = len_ff;
      left_nx   = left_ff;
      inpay_nx  = inpay_ff;
      pad_nx    = pad_ff;
      kind_nx   = kind_ff;
      pidx_nx   = pidx_ff;
      pw_nx     = pw_ff;
      ph_nx     = ph_ff;
      pf_nx     = pf_ff;
      fw_nx     = fw_ff;
      fh_nx     = fh_ff;
      ff_nx     = ff_ff;
      frames_nx = frames_ff;
      finish    = 1'b0;

      if (step) begin
         if (pos_ff < POS_BITS'(4) || (pos_ff >= POS_BITS'(8) && pos_ff < POS_BITS'(12))) begin
            if (b != expect_byte) begin
               magic_nx = 1'b0;
            end
         end else if (pos_ff >= POS_BITS'(12)) begin
            if (inpay_ff) begin
               if (kind_ff == KIND_VP8X) begin
                  case (pidx_ff)
                     4'd0: pf_nx = b;
                     4'd4: pw_nx[7:0]   = b;
                     4'd5: pw_nx[15:8]  = b;
                     4'd6: pw_nx[23:16] = b;
                     4'd7: ph_nx[7:0]   = b;
                     4'd8: ph_nx[15:8]  = b;
                     4'd9: ph_nx[23:16] = b;
                     default: ;
                  endcase
               end else if (kind_ff == KIND_VP8) begin
                  case (pidx_ff)
                     4'd6: pw_nx[7:0]  = b;
                     4'd7: pw_nx[15:8] = b;
                     4'd8: ph_nx[7:0]  = b;
                     4'd9: ph_nx[15:8] = b;
                     default: ;
                  endcase
               end
               if (pidx_ff != 4'hf) begin
                  pidx_nx = pidx_ff + 4'd1;
               end
               left_nx = left_ff - 32'd1;
               finish  = (left_ff == 32'd1);
            end else if (pad_ff) begin
               pad_nx = 1'b0;
            end else begin
               case (hidx_ff)
                  3'd4: len_nx = {24'd0, b};
                  3'd5: len_nx[15:8]  = b;
                  3'd6: len_nx[23:16] = b;
                  3'd7: len_nx = len_full;
                  default: tag_nx = {tag_ff[23:0], b};
               endcase
               hidx_nx = hidx_ff + 3'd1;
               if (hidx_ff == 3'd7) begin
                  if (tag_ff == TAG_VP8X && len_full >= 32'd10) begin
                     kind_nx = KIND_VP8X;
                  end else if (tag_ff == TAG_VP8 && len_full >= 32'd10) begin
                     kind_nx = KIND_VP8;
                  end else if (tag_ff == TAG_ANMF) begin
                     kind_nx = KIND_ANMF;
                  end else begin
                     kind_nx = KIND_OTHER;
                  end
                  pidx_nx = 4'd0;
                  pw_nx   = 24'd0;
                  ph_nx   = 24'd0;
                  pf_nx   = 8'd0;
                  left_nx = len_full;
                  pad_nx  = 1'b0;
                  if (len_full == 32'd0) begin
                     finish = 1'b1;
                  end else begin
                     inpay_nx = 1'b1;
                  end
               end
            end

            // close the chunk: commit what it carried
            if (finish) begin
               if (kind_nx == KIND_VP8X) begin
                  fw_nx = {1'b0, pw_nx} + DIM_BITS'(1);
                  fh_nx = {1'b0, ph_nx} + DIM_BITS'(1);
                  ff_nx = pf_nx;
               end else if (kind_nx == KIND_VP8) begin
                  fw_nx = DIM_BITS'(pw_nx[13:0]);
                  fh_nx = DIM_BITS'(ph_nx[13:0]);
               end else if (kind_nx == KIND_ANMF) begin
                  if (frames_ff != '1) begin
                     frames_nx = frames_ff + 32'd1;
                  end
               end
               inpay_nx = 1'b0;
               pad_nx   = len_nx[0];
            end
         end
         if (pos_ff != POS_BITS'(POS_SAT)) begin
            pos_nx = pos_ff + POS_BITS'(1);
         end
      end
   end

   // snapshot of the state as it stands after the final byte
   always_comb begin
      snap.width        = fw_nx;
      snap.height       = fh_nx;
      snap.frames       = frames_nx;
      snap.flags        = ff_nx;
      snap.check_limits = 1'b0;
      snap.early_status = STATUS_OK;
      if (pos_ff < POS_BITS'(POS_SAT)) begin
         snap.early_status = STATUS_TRUNCATED;
      end else if (!magic_nx) begin
         snap.early_status = STATUS_BAD_MAGIC;
      end else if (inpay_nx) begin
         snap.early_status = STATUS_TRUNCATED;
      end else if (fw_nx == '0 || fh_nx == '0) begin
         snap.early_status = STATUS_CORRUPT;
      end else begin
         snap.check_limits = 1'b1;
      end
   end

   // a final byte returns everything to the start of a new file
   assign clear = step && req_data.last_byte;

   always_comb begin
      pos_in    = clear ? '0 : pos_nx;
      magic_in  = clear ? 1'b1 : magic_nx;
      hidx_in   = clear ? '0 : hidx_nx;
      tag_in    = clear ? '0 : tag_nx;
      len_in    = clear ? '0 : len_nx;
      left_in   = clear ? '0 : left_nx;
      inpay_in  = clear ? 1'b0 : inpay_nx;
      pad_in    = clear ? 1'b0 : pad_nx;
      kind_in   = clear ? KIND_OTHER : kind_nx;
      pidx_in   = clear ? '0 : pidx_nx;
      pw_in     = clear ? '0 : pw_nx;
      ph_in     = clear ? '0 : ph_nx;
      pf_in     = clear ? '0 : pf_nx;
      fw_in     = clear ? '0 : fw_nx;
      fh_in     = clear ? '0 : fh_nx;
      ff_in     = clear ? '0 : ff_nx;
      frames_in = clear ? 32'd1 : frames_nx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         magic_ff  <= 1'b1;
         hidx_ff   <= '0;
         tag_ff    <= '0;
         len_ff    <= '0;
         left_ff   <= '0;
         inpay_ff  <= 1'b0;
         pad_ff    <= 1'b0;
         kind_ff   <= KIND_OTHER;
         pidx_ff   <= '0;
         pw_ff     <= '0;
         ph_ff     <= '0;
         pf_ff     <= '0;
         fw_ff     <= '0;
         fh_ff     <= '0;
         ff_ff     <= '0;
         frames_ff <= 32'd1;
      end else begin
         pos_ff    <= pos_in;
         magic_ff  <= magic_in;
         hidx_ff   <= hidx_in;
         tag_ff    <= tag_in;
         len_ff    <= len_in;
         left_ff   <= left_in;
         inpay_ff  <= inpay_in;
         pad_ff    <= pad_in;
         kind_ff   <= kind_in;
         pidx_ff   <= pidx_in;
         pw_ff     <= pw_in;
         ph_ff     <= ph_in;
         pf_ff     <= pf_in;
         fw_ff     <= fw_in;
         fh_ff     <= fh_in;
         ff_ff     <= ff_in;
         frames_ff <= frames_in;
      end
   end

endmodule
`default_nettype wire

### design/wrhp_result_form.sv
// ---------------------------------------------------------------------------
// wrhp_result_form
// Limit compares and final status selection for one end-of-file snapshot.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module wrhp_result_form
   import wrhp_pkg::*;
(
   input  wire prod_type  prod,
   input  wire cfg_type   cfg,
   output rsp_type        rsp
);

   logic       over;
   logic [2:0] status;

   assign over = (prod.snap.width > cfg.max_width)
              || (prod.snap.height > cfg.max_height)
              || (prod.pixels > PROD_BITS'(cfg.max_pixels));

   always_comb begin
      if (!prod.snap.check_limits) begin
         status = prod.snap.early_status;
      end else if (over) begin
         status = STATUS_DIM_REJECT;
      end else if (cfg.header_only_mode) begin
         status = STATUS_OK;
      end else begin
         status = STATUS_UNSUPPORTED;
      end
   end

   always_comb begin
      rsp.status = status;
      if (status == STATUS_OK || status == STATUS_UNSUPPORTED) begin
         rsp.image_width   = prod.snap.width;
         rsp.image_height  = prod.snap.height;
         rsp.frame_total   = prod.snap.frames;
         rsp.alpha_present = prod.snap.flags[4];
         rsp.format_flags  = prod.snap.flags;
      end else begin
         rsp.image_width   = '0;
         rsp.image_height  = '0;
         rsp.frame_total   = 32'd1;
         rsp.alpha_present = 1'b0;
         rsp.format_flags  = '0;
      end
   end

endmodule
`default_nettype wire

### design/wrhp_port_checker.sv
// ---------------------------------------------------------------------------
// wrhp_port_checker
// Port-level checks on the header probe response channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module wrhp_port_checker
   import wrhp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    rsp_valid,
   input  wire logic    rsp_ready,
   input  wire rsp_type rsp_data
);

   `WRHP_ASSERT_ALWAYS(a_idle_after_reset, clock, reset |=> !rsp_valid, "response valid after reset")

   `WRHP_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "stalled response dropped or changed")

   `WRHP_ASSERT(a_error_fields, clock, reset, rsp_valid && rsp_data.status != STATUS_OK && rsp_data.status != STATUS_UNSUPPORTED |-> rsp_data.image_width == '0 && rsp_data.image_height == '0 && rsp_data.frame_total == 32'd1 && rsp_data.format_flags == '0 && !rsp_data.alpha_present, "error response carries data")

   `WRHP_ASSERT(a_good_dims, clock, reset, rsp_valid && (rsp_data.status == STATUS_OK || rsp_data.status == STATUS_UNSUPPORTED) |-> rsp_data.image_width != '0 && rsp_data.image_height != '0 && rsp_data.frame_total != '0, "good response with zero size or frames")

   `WRHP_ASSERT(a_alpha_flag, clock, reset, rsp_valid |-> rsp_data.alpha_present == rsp_data.format_flags[4], "alpha flag disagrees with format flags")

endmodule

bind webp_riff_header_probe_top wrhp_port_checker u_port_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
`default_nettype wire

### dv/webp_riff_header_probe_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// webp_riff_header_probe_top_tb
// Self-checking bench for the WebP RIFF header probe. Whole files are built
// byte by byte: hand-made corner files first, then random well-formed files
// mixed with broken and garbage ones. These are streamed through the request
// channel with bursty gaps and a stalling response side. A scoreboard class
// predicts the report of every file and checks each response field by field.
// ---------------------------------------------------------------------------
module webp_riff_header_probe_top_tb;
   import wrhp_pkg::*;

   localparam int unsigned CYCLE_LIMIT     = 400000;
   localparam int          HOLD_OFF_CYCLES = 500;
   localparam int          DRAIN_QUIET     = 8;

   // ------------------------------------------------------------------------
   // Scoreboard: tracks the container walk of the current file and queues
   // the report expected at its last byte.
   // ------------------------------------------------------------------------
   class probe_scoreboard;
      logic [DIM_BITS-1:0] lim_width, lim_height;
      logic [PIX_BITS-1:0] lim_pixels;
      logic                header_only;

      int unsigned         pos;
      logic                magic_ok;
      logic [2:0]          hdr_idx;
      logic [31:0]         tag, clen;
      logic [32:0]         remaining;
      logic                in_pl, pad_due;
      logic [1:0]          kind;
      logic [3:0]          pl_idx;
      logic [23:0]         pend_w, pend_h;
      logic [7:0]          pend_flags;
      logic [DIM_BITS-1:0] fnd_w, fnd_h;
      logic [7:0]          fnd_flags;
      logic [31:0]         frames;

      rsp_type             pending_reports[$];
      int                  errors;

      function new();
         lim_width   = RESET_MAX_WIDTH;
         lim_height  = RESET_MAX_HEIGHT;
         lim_pixels  = RESET_MAX_PIXELS;
         header_only = 1'b1;
         errors      = 0;
         restart();
      endfunction

      function void restart();
         pos = 0; magic_ok = 1'b1; hdr_idx = '0; tag = '0; clen = '0;
         remaining = '0; in_pl = 1'b0; pad_due = 1'b0; kind = KIND_OTHER;
         pl_idx = '0; pend_w = '0; pend_h = '0; pend_flags = '0;
         fnd_w = '0; fnd_h = '0; fnd_flags = '0; frames = 32'd1;
      endfunction

      function void write_limit(logic [1:0] idx, logic [PIX_BITS-1:0] val);
         case (idx)
            CSR_MAX_WIDTH:   lim_width   = val[DIM_BITS-1:0];
            CSR_MAX_HEIGHT:  lim_height  = val[DIM_BITS-1:0];
            CSR_MAX_PIXELS:  lim_pixels  = val;
            CSR_HEADER_ONLY: header_only = val[0];
            default: ;
         endcase
      endfunction

      function int outstanding();
         return pending_reports.size();
      endfunction

      // last payload byte of a chunk: commit what it carried
      function void close_chunk();
         case (kind)
            KIND_VP8X: begin
               fnd_w     = DIM_BITS'(pend_w) + 1'b1;
               fnd_h     = DIM_BITS'(pend_h) + 1'b1;
               fnd_flags = pend_flags;
            end
            KIND_VP8: begin
               fnd_w = DIM_BITS'(pend_w[13:0]);
               fnd_h = DIM_BITS'(pend_h[13:0]);
            end
            KIND_ANMF: if (frames != 32'hffff_ffff) frames++;
            default: ;
         endcase
         in_pl   = 1'b0;
         pad_due = clen[0];
      endfunction

      function void take_payload(logic [7:0] b);
         int i;
         i = pl_idx;
         if (kind == KIND_VP8X) begin
            if (i == 0) pend_flags = b;
            else if (i >= 4 && i <= 6) pend_w[8*(i-4) +: 8] = b;
            else if (i >= 7 && i <= 9) pend_h[8*(i-7) +: 8] = b;
         end else if (kind == KIND_VP8) begin
            if (i == 6 || i == 7) pend_w[8*(i-6) +: 8] = b;
            else if (i == 8 || i == 9) pend_h[8*(i-8) +: 8] = b;
         end
         if (pl_idx != 4'hf) pl_idx++;
         remaining--;
         if (remaining == 0) close_chunk();
      endfunction

      function void take_chunk_byte(logic [7:0] b);
         int i;
         i = hdr_idx;
         if (in_pl) begin
            take_payload(b);
            return;
         end
         if (pad_due) begin
            pad_due = 1'b0;
            return;
         end
         if (i < 4) tag = {tag[23:0], b};
         else if (i == 4) clen = {24'd0, b};
         else clen[8*(i-4) +: 8] = b;
         hdr_idx++;
         if (hdr_idx != 0) return;

         // full header seen: classify and open the payload
         kind = KIND_OTHER;
         if (tag == TAG_VP8X && clen >= 10) kind = KIND_VP8X;
         else if (tag == TAG_VP8 && clen >= 10) kind = KIND_VP8;
         else if (tag == TAG_ANMF) kind = KIND_ANMF;
         pl_idx = '0; pend_w = '0; pend_h = '0; pend_flags = '0;
         remaining = {1'b0, clen};
         pad_due = 1'b0;
         if (remaining == 0) close_chunk();
         else in_pl = 1'b1;
      endfunction

      function void note_request(req_type r);
         rsp_type     res;
         logic [2:0]  st;
         logic [63:0] area;
         int unsigned at;
         logic [31:0] riff, webp;
         riff = MAGIC_RIFF;
         webp = MAGIC_WEBP;
         at   = pos;
         if (at < 4) begin
            if (r.data_byte != riff[8*(3-at) +: 8]) magic_ok = 1'b0;
         end else if (at >= 8 && at < 12) begin
            if (r.data_byte != webp[8*(11-at) +: 8]) magic_ok = 1'b0;
         end else if (at >= 12) begin
            take_chunk_byte(r.data_byte);
         end
         if (pos != 32'hffff_ffff) pos++;
         if (!r.last_byte) return;

         area = 64'(fnd_w) * 64'(fnd_h);
         if (at < 19) st = STATUS_TRUNCATED;
         else if (!magic_ok) st = STATUS_BAD_MAGIC;
         else if (in_pl) st = STATUS_TRUNCATED;
         else if (fnd_w == 0 || fnd_h == 0) st = STATUS_CORRUPT;
         else if (fnd_w > lim_width || fnd_h > lim_height || area > 64'(lim_pixels))
            st = STATUS_DIM_REJECT;
         else st = header_only ? STATUS_OK : STATUS_UNSUPPORTED;

         res = '0;
         res.status      = st;
         res.frame_total = 32'd1;
         if (st == STATUS_OK || st == STATUS_UNSUPPORTED) begin
            res.image_width   = fnd_w;
            res.image_height  = fnd_h;
            res.frame_total   = frames;
            res.alpha_present = fnd_flags[4];
            res.format_flags  = fnd_flags;
         end
         pending_reports.push_back(res);
         restart();
      endfunction

      function void compare_field(string field, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            errors++;
            if (errors <= 40)
               $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (pending_reports.size() == 0) begin
            errors++;
            if (errors <= 40)
               $display("%0t: response with nothing outstanding: expected none, actual %h",
                        $time, got);
            return;
         end
         want = pending_reports.pop_front();
         compare_field("status", want.status, got.status);
         compare_field("image_width", want.image_width, got.image_width);
         compare_field("image_height", want.image_height, got.image_height);
         compare_field("frame_total", want.frame_total, got.frame_total);
         compare_field("alpha_present", want.alpha_present, got.alpha_present);
         compare_field("format_flags", want.format_flags, got.format_flags);
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // DUT hookup; every input starts at a known value.
   // ------------------------------------------------------------------------
   logic                clock;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   req_type             req_data  = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rsp_type             rsp_data;
   logic                csr_we    = 1'b0;
   logic [1:0]          csr_index = CSR_MAX_WIDTH;
   logic [PIX_BITS-1:0] csr_wdata = '0;

   probe_scoreboard board = new();

   logic [7:0]  fbytes[$];       // file under construction
   int unsigned bytes_sent  = 0;
   int unsigned files_sent  = 0;
   int          burst_left  = 0;
   logic        hold_off_req = 1'b0;

   webp_riff_header_probe_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog: end the run with an error report if the main sequence has not finished by CYCLE_LIMIT.
   initial begin
      int unsigned cycles;
      cycles = 0;
      while (cycles <= CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("webp_riff_header_probe_top_tb: errors");
      $finish;
   end

   // Sample both handshakes at the rising edge; the scoreboard sees every
   // accepted request byte and every accepted response.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) board.note_request(req_data);
      if (!reset && rsp_valid && rsp_ready) board.check_response(rsp_data);
   end

   // Response side: pick a new stall mode after each span of random length. When asked,
   // hold ready low for a long stretch so the result stages back up and
   // the request side stalls.
   initial begin
      int mode;
      int span;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(8, 80);
         repeat (span) begin
            @(negedge clock);
            if (hold_off_req) begin
               rsp_ready <= 1'b0;
               repeat (HOLD_OFF_CYCLES) @(posedge clock);
               hold_off_req = 1'b0;
            end else begin
               case (mode)
                  0:       rsp_ready <= 1'b1;
                  1:       rsp_ready <= 1'($urandom_range(0, 1));
                  2:       rsp_ready <= ($urandom_range(0, 3) == 0);
                  default: rsp_ready <= ~rsp_ready;
               endcase
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // File construction
   // ------------------------------------------------------------------------

   // push a four-character code in text order
   function automatic void push_word(logic [31:0] w);
      for (int k = 3; k >= 0; k--) fbytes.push_back(w[8*k +: 8]);
   endfunction

   function automatic void push_le32(logic [31:0] v);
      for (int k = 0; k < 4; k++) fbytes.push_back(v[8*k +: 8]);
   endfunction

   // RIFF magic, random size field, WEBP magic
   function automatic void begin_file();
      fbytes.delete();
      push_word(MAGIC_RIFF);
      push_le32($urandom);
      push_word(MAGIC_WEBP);
   endfunction

   // append a chunk with random payload and pad; return the payload offset
   function automatic int add_chunk(logic [31:0] tag, int unsigned len);
      int at;
      push_word(tag);
      push_le32(len);
      at = fbytes.size();
      repeat (len + (len & 1)) fbytes.push_back(8'($urandom));
      return at;
   endfunction

   function automatic void put_le(int at, logic [23:0] v, int n);
      for (int k = 0; k < n; k++) fbytes[at + k] = v[8*k +: 8];
   endfunction

   // dimension fields hold size minus one
   function automatic void add_vp8x(int unsigned len, logic [7:0] flags,
                                    logic [23:0] wm1, logic [23:0] hm1);
      int at;
      at = add_chunk(TAG_VP8X, len);
      if (len >= 10) begin
         fbytes[at] = flags;
         put_le(at + 4, wm1, 3);
         put_le(at + 7, hm1, 3);
      end
   endfunction

   // the top two bits of each field are scale bits and get dropped
   function automatic void add_vp8(int unsigned len, logic [15:0] w, logic [15:0] h);
      int at;
      at = add_chunk(TAG_VP8, len);
      if (len >= 10) begin
         put_le(at + 6, 24'(w), 2);
         put_le(at + 8, 24'(h), 2);
      end
   endfunction

   function automatic logic [23:0] pick_dim();
      case ($urandom_range(0, 9))
         0:       return 24'hffffff - 24'($urandom_range(0, 3));
         1:       return 24'($urandom);
         default: return 24'($urandom_range(0, 299));
      endcase
   endfunction

   function automatic logic [15:0] pick_vp8_dim();
      if ($urandom_range(0, 4) == 0) return 16'($urandom);
      return {2'($urandom), 14'($urandom_range(0, 299))};
   endfunction

   function automatic void add_random_chunk();
      case ($urandom_range(0, 5))
         0, 1: add_vp8x($urandom_range(10, 14), 8'($urandom), pick_dim(), pick_dim());
         2:    add_vp8($urandom_range(10, 13), pick_vp8_dim(), pick_vp8_dim());
         3:    void'(add_chunk(TAG_ANMF, $urandom_range(0, 5)));
         4: begin
            // dimension chunk too short to count
            if ($urandom_range(0, 1) == 1)
               add_vp8x($urandom_range(0, 9), 8'($urandom), pick_dim(), pick_dim());
            else
               add_vp8($urandom_range(0, 9), pick_vp8_dim(), pick_vp8_dim());
         end
         default: void'(add_chunk($urandom, $urandom_range(0, 5)));
      endcase
   endfunction

   // Mostly well-formed files; the rest garbage, bad magic, cut short,
   // trailing partial headers or a chunk that claims more than it carries.
   function automatic void random_file();
      int pick;
      int idx;
      int cut;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         fbytes.delete();
         repeat ($urandom_range(1, 40)) fbytes.push_back(8'($urandom));
         return;
      end
      begin_file();
      repeat ($urandom_range(1, 4)) add_random_chunk();
      if (pick < 18) begin
         idx = $urandom_range(0, 7);
         if (idx >= 4) idx += 4;
         fbytes[idx] ^= 8'(1 << $urandom_range(0, 7));
      end else if (pick < 28) begin
         cut = $urandom_range(1, fbytes.size());
         while (fbytes.size() > cut) void'(fbytes.pop_back());
      end else if (pick < 34) begin
         repeat ($urandom_range(1, 7)) fbytes.push_back(8'($urandom));
      end else if (pick < 38) begin
         push_word($urandom);
         push_le32($urandom);
         repeat ($urandom_range(0, 6)) fbytes.push_back(8'($urandom));
      end
   endfunction

   // ------------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------------

   // Offer one request byte and hold it until taken. Valid drops between
   // bursts; some bursts are long stretches with no gaps.
   task automatic send_byte(logic [7:0] b, logic lst);
      if (burst_left == 0) begin
         repeat ($urandom_range(1, 6)) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(150, 300)
                                                  : $urandom_range(1, 40);
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= req_type'{data_byte: b, last_byte: lst};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_file();
      for (int k = 0; k < fbytes.size(); k++) send_byte(fbytes[k], k == fbytes.size() - 1);
      files_sent++;
   endtask

   // Drop valid and wait for every outstanding report, then let the
   // pipeline settle so the limit registers can be touched safely.
   task automatic pause_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.outstanding() != 0) @(negedge clock);
      repeat (DRAIN_QUIET) @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [PIX_BITS-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      board.write_limit(idx, val);
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic program_limits(logic [DIM_BITS-1:0] w, logic [DIM_BITS-1:0] h,
                                 logic [PIX_BITS-1:0] px, logic mode);
      write_csr(CSR_MAX_WIDTH, PIX_BITS'(w));
      write_csr(CSR_MAX_HEIGHT, PIX_BITS'(h));
      write_csr(CSR_MAX_PIXELS, px);
      write_csr(CSR_HEADER_ONLY, PIX_BITS'(mode));
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      int unsigned phase_bytes;
      int unsigned phase_files;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // --- hand-made files under the reset limits ---
      // extended header with alpha, 100 x 50
      begin_file(); add_vp8x(10, 8'h10, 24'd99, 24'd49); send_file();
      // lossy header: scale bits set on both fields
      begin_file(); add_vp8(10, 16'hc280, 16'hffff); send_file();
      // odd-length extended header, three frame chunks and an odd chunk with pad
      begin_file(); add_vp8x(11, 8'hef, 24'd7, 24'd9);
      void'(add_chunk(TAG_ANMF, 0)); void'(add_chunk(TAG_ANMF, 3));
      void'(add_chunk(TAG_ANMF, 4)); void'(add_chunk(32'h4558_4946, 1)); send_file();
      // nineteen bytes: too short
      begin_file(); repeat (7) fbytes.push_back(8'($urandom)); send_file();
      // exactly twenty bytes: one empty frame chunk, no dimensions
      begin_file(); void'(add_chunk(TAG_ANMF, 0)); send_file();
      // chunk header cut short at the end is ignored
      begin_file(); add_vp8x(10, 8'h00, 24'd3, 24'd3);
      repeat (5) fbytes.push_back(8'($urandom)); send_file();
      // bad RIFF magic, then bad WEBP magic
      begin_file(); add_vp8x(10, 8'h00, 24'd3, 24'd3); fbytes[0] = 8'h72; send_file();
      begin_file(); add_vp8x(10, 8'h00, 24'd3, 24'd3); fbytes[11] ^= 8'h01; send_file();
      // payload cut off mid-chunk
      begin_file(); add_vp8x(10, 8'h10, 24'd3, 24'd3);
      repeat (3) void'(fbytes.pop_back()); send_file();
      // short extended header is skipped, leaving no dimensions
      begin_file(); add_vp8x(9, 8'h10, 24'd3, 24'd3); send_file();
      // widest possible width, rejected by limit
      begin_file(); add_vp8x(10, 8'h00, 24'hffffff, 24'd0); send_file();
      // exactly at every limit, then one past the width limit
      begin_file(); add_vp8x(10, 8'h00, 24'd16383, 24'd16383); send_file();
      begin_file(); add_vp8x(10, 8'h00, 24'd16384, 24'd0); send_file();
      // missing pad byte on the final odd chunk is ignored
      begin_file(); add_vp8x(10, 8'h02, 24'd5, 24'd6);
      void'(add_chunk(32'h4943_4350, 3)); void'(fbytes.pop_back()); send_file();
      // one-byte file
      fbytes.delete(); fbytes.push_back(8'h52); send_file();
      // later dimension chunk wins, flags stay from the extended header
      begin_file(); add_vp8x(10, 8'h30, 24'd10, 24'd20); add_vp8(10, 16'd33, 16'd44);
      send_file();
      // empty extended header chunk counts as other
      begin_file(); add_vp8x(0, 8'h00, 24'd0, 24'd0); add_vp8(10, 16'd8, 16'd9); send_file();
      // lossy header with zero width
      begin_file(); add_vp8(10, 16'hc000, 16'd12); send_file();
      // chunk claiming the largest length, then the file ends
      begin_file(); push_word(TAG_ANMF); push_le32(32'hffff_ffff);
      repeat (3) fbytes.push_back(8'($urandom)); send_file();
      pause_for_results();

      // --- largest limits, decode requested ---
      program_limits(25'd16777216, 25'd16777216, '1, 1'b0);
      // product 2^48 is one past the pixel limit
      begin_file(); add_vp8x(10, 8'h3c, 24'hffffff, 24'hffffff); send_file();
      begin_file(); add_vp8x(10, 8'h10, 24'hffffff, 24'hfffffe); send_file();
      pause_for_results();

      // --- smallest limits ---
      program_limits(25'd1, 25'd1, 48'd1, 1'b1);
      begin_file(); add_vp8x(10, 8'h10, 24'd0, 24'd0); send_file();
      begin_file(); add_vp8(10, 16'd1, 16'd2); send_file();
      pause_for_results();

      // --- random files across several limit settings ---
      // the first phase runs under a long response hold-off and sends
      // enough files to back up every result stage
      hold_off_req = 1'b1;
      for (int p = 0; p < 6; p++) begin
         case (p % 3)
            0: program_limits(25'($urandom_range(1, 400)), 25'($urandom_range(1, 400)),
                              48'($urandom_range(1, 120000)), 1'($urandom));
            1: program_limits(RESET_MAX_WIDTH, RESET_MAX_HEIGHT, RESET_MAX_PIXELS,
                              1'($urandom));
            default: program_limits(25'd16777216, 25'd16777216,
                                    {16'($urandom), 32'($urandom)}, 1'($urandom));
         endcase
         phase_bytes = bytes_sent;
         phase_files = files_sent;
         while (bytes_sent - phase_bytes < 60 ||
                (p == 0 && files_sent - phase_files < 5)) begin
            random_file();
            send_file();
         end
         pause_for_results();
      end

      // watch a little longer for stray responses
      repeat (DRAIN_QUIET) @(negedge clock);
      if (board.errors == 0 && board.outstanding() == 0)
         $display("webp_riff_header_probe_top_tb: clean");
      else
         $display("webp_riff_header_probe_top_tb: errors");
      $finish;
   end

endmodule
